// File: rtl/kcct_pkg.sv
// Shared types and constants for the keyed cookie cache table.
package kcct_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int KEY_BYTES     = 8;
   localparam int QUEUE_DEPTH   = 2;

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Only the leading KEY_BYTES bytes of the cookie take part in a match.
   localparam logic [63:0] KEY_MASK = {64{1'b1}} << (8 * (8 - KEY_BYTES));

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_TAKE   = 2'd1;
   localparam logic [1:0] OP_CHECK  = 2'd2;

   localparam logic [2:0] STATUS_ADDED     = 3'd0;
   localparam logic [2:0] STATUS_REPLACED  = 3'd1;
   localparam logic [2:0] STATUS_FOUND     = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;

   typedef struct packed {
      logic        do_insert;
      logic        do_take;
      logic        do_check;
      logic [63:0] key;
      logic [15:0] ctype;
      logic [31:0] payload;
      logic [31:0] now_time;
   } cmd_type;

   typedef struct packed {
      logic [63:0] key;
      logic [15:0] ctype;
      logic [31:0] payload;
      logic [31:0] stime;
   } entry_type;

endpackage

// File: rtl/keyed_cookie_cache_table.sv
// Top level of the keyed cookie cache table.
//
// A request is transferred at a rising edge where start is high and busy is
// low. It carries an operation (insert/refresh, take, check), a 64-bit cookie,
// a 16-bit cookie type, a payload handle and the current time. Every request
// produces exactly one result, shown on the rsp_ ports for one cycle while
// rsp_strobe is high; the receiver cannot stall, so results are never held.
// Requests pass through an intake register and a two-entry queue, then the
// table engine scans the sixteen slots one per cycle through the slot memory
// read port, stopping at the first matching slot, so it scans 1 to 16 slots.
// The engine holds one item at a time and takes the next from the queue only
// once the current item's scan and finish state are done; the result is then
// registered onto the rsp_ ports. A request waiting in the queue also waits
// until the engine is through with the requests ahead of it.
// busy rises only when the intake register is loaded and the queue is full.
// Reset empties the table (all slots invalid), the queue and the intake; no
// clearing pass is needed, so requests are taken right after reset.
module keyed_cookie_cache_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_cookie_value,
   input  logic [15:0] req_cookie_type,
   input  logic [31:0] req_payload,
   input  logic [31:0] req_now_time,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_entry_payload,
   output logic [31:0] rsp_entry_time
);

   logic              push_valid, q_full, q_valid, pop;
   kcct_pkg::cmd_type push_cmd, q_cmd;

   kcct_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_cookie_value (req_cookie_value),
      .req_cookie_type  (req_cookie_type),
      .req_payload      (req_payload),
      .req_now_time     (req_now_time),
      .q_full           (q_full),
      .push_valid       (push_valid),
      .push_cmd         (push_cmd)
   );

   kcct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .pop        (pop)
   );

   kcct_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_entry_payload (rsp_entry_payload),
      .rsp_entry_time    (rsp_entry_time)
   );

endmodule

// File: rtl/kcct_front.sv
// Request intake: accepts a request, decodes its operation and hands it to the queue.
module kcct_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_operation,
   input  logic [63:0]       req_cookie_value,
   input  logic [15:0]       req_cookie_type,
   input  logic [31:0]       req_payload,
   input  logic [31:0]       req_now_time,
   input  logic              q_full,
   output logic              push_valid,
   output kcct_pkg::cmd_type push_cmd
);

   logic              front_valid_ff, front_valid_in;
   kcct_pkg::cmd_type front_cmd_ff;
   kcct_pkg::cmd_type decoded;
   logic              accept;

   assign push_valid = front_valid_ff && !q_full;
   assign push_cmd   = front_cmd_ff;
   assign busy       = front_valid_ff && q_full;
   assign accept     = start && !busy;

   always_comb begin
      decoded           = '0;
      decoded.key       = req_cookie_value;
      decoded.ctype     = req_cookie_type;
      decoded.payload   = req_payload;
      decoded.now_time  = req_now_time;
      case (req_operation)
         kcct_pkg::OP_INSERT: decoded.do_insert = 1'b1;
         kcct_pkg::OP_TAKE:   decoded.do_take   = 1'b1;
         kcct_pkg::OP_CHECK:  decoded.do_check  = 1'b1;
         default: ;
      endcase
   end

   assign front_valid_in = accept || (front_valid_ff && !push_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_cmd_ff <= decoded;
      end
   end

endmodule

// File: rtl/kcct_queue.sv
// Short command queue between the intake and the table engine.
module kcct_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  kcct_pkg::cmd_type push_cmd,
   output logic              q_full,
   output logic              q_valid,
   output kcct_pkg::cmd_type q_cmd,
   input  logic              pop
);

   kcct_pkg::cmd_type                slots_ff [kcct_pkg::QUEUE_DEPTH];
   logic [kcct_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [kcct_pkg::QCNT_W-1:0]      count_ff;

   localparam logic [kcct_pkg::QCNT_W-1:0] DEPTH_CNT = kcct_pkg::QCNT_W'(kcct_pkg::QUEUE_DEPTH);
   localparam logic [kcct_pkg::QPTR_W-1:0] LAST_PTR  =
      kcct_pkg::QPTR_W'(kcct_pkg::QUEUE_DEPTH - 1);

   assign q_full  = (count_ff == DEPTH_CNT);
   assign q_valid = (count_ff != '0);
   assign q_cmd   = slots_ff[rd_ptr_ff];

   function automatic logic [kcct_pkg::QPTR_W-1:0] bump(input logic [kcct_pkg::QPTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push_valid && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push_valid) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && q_full))
      else $error("queue written while full");

endmodule

// File: rtl/kcct_back.sv
// Table engine: scans the slot memory for a command and writes back the outcome.
module kcct_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  kcct_pkg::cmd_type q_cmd,
   output logic              pop,
   output logic              rsp_strobe,
   output logic [2:0]        rsp_status,
   output logic [31:0]       rsp_entry_payload,
   output logic [31:0]       rsp_entry_time
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   localparam logic [kcct_pkg::IDX_W-1:0] LAST_IDX = kcct_pkg::IDX_W'(kcct_pkg::TABLE_ENTRIES - 1);

   kcct_pkg::entry_type             mem [kcct_pkg::TABLE_ENTRIES];
   kcct_pkg::entry_type             rd_data_ff;
   logic [kcct_pkg::TABLE_ENTRIES-1:0] valid_ff;

   state_type                       state_ff, state_in;
   kcct_pkg::cmd_type               cmd_ff;
   logic [kcct_pkg::IDX_W-1:0]      idx_ff;
   logic                            match_found_ff, free_found_ff;
   logic [kcct_pkg::IDX_W-1:0]      match_idx_ff, free_idx_ff;
   logic [31:0]                     match_pay_ff, match_time_ff;

   logic                            rsp_strobe_ff;
   logic [2:0]                      rsp_status_ff;
   logic [31:0]                     rsp_pay_ff, rsp_time_ff;

   logic                            hit, is_free, last;
   logic                            rd_en;
   logic [kcct_pkg::IDX_W-1:0]      rd_addr;
   logic                            wr_en;
   logic [kcct_pkg::IDX_W-1:0]      wr_addr;
   kcct_pkg::entry_type             wr_data;
   logic [2:0]                      res_status;
   logic [31:0]                     res_pay, res_time;

   assign hit = (state_ff == S_SCAN) && valid_ff[idx_ff] &&
                (rd_data_ff.ctype == cmd_ff.ctype) &&
                (((rd_data_ff.key ^ cmd_ff.key) & kcct_pkg::KEY_MASK) == 64'd0);
   assign is_free = !valid_ff[idx_ff];
   assign last    = (idx_ff == LAST_IDX);

   assign pop     = (state_ff == S_IDLE) && q_valid;
   assign rd_en   = pop || ((state_ff == S_SCAN) && !hit && !last);
   assign rd_addr = (state_ff == S_IDLE) ? '0 : idx_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (q_valid) state_in = S_SCAN;
         S_SCAN:   if (hit || last) state_in = S_FINISH;
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // The match, if any, wins over a free slot; a free slot matters only for a new key.
   always_comb begin
      res_status = kcct_pkg::STATUS_NOT_FOUND;
      res_pay    = '0;
      res_time   = '0;
      wr_en      = 1'b0;
      wr_addr    = match_found_ff ? match_idx_ff : free_idx_ff;
      if (cmd_ff.do_insert) begin
         if (match_found_ff || free_found_ff) begin
            res_status = match_found_ff ? kcct_pkg::STATUS_REPLACED : kcct_pkg::STATUS_ADDED;
            res_pay    = cmd_ff.payload;
            res_time   = cmd_ff.now_time;
            wr_en      = (state_ff == S_FINISH);
         end else begin
            res_status = kcct_pkg::STATUS_FULL;
         end
      end else if ((cmd_ff.do_take || cmd_ff.do_check) && match_found_ff) begin
         res_status = kcct_pkg::STATUS_FOUND;
         res_pay    = match_pay_ff;
         res_time   = match_time_ff;
      end
   end

   assign wr_data.key     = cmd_ff.key;
   assign wr_data.ctype   = cmd_ff.ctype;
   assign wr_data.payload = cmd_ff.payload;
   assign wr_data.stime   = cmd_ff.now_time;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == S_FINISH);
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if ((state_ff == S_FINISH) && cmd_ff.do_take && match_found_ff) begin
            valid_ff[match_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff         <= q_cmd;
         idx_ff         <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else if (state_ff == S_SCAN) begin
         if (hit) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= idx_ff;
            match_pay_ff   <= rd_data_ff.payload;
            match_time_ff  <= rd_data_ff.stime;
         end else begin
            if (is_free && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= idx_ff;
            end
            if (!last) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
      if (state_ff == S_FINISH) begin
         rsp_status_ff <= res_status;
         rsp_pay_ff    <= res_pay;
         rsp_time_ff   <= res_time;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_payload = rsp_pay_ff;
   assign rsp_entry_time    = rsp_time_ff;

   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_FINISH))
      else $error("result strobe without a finished command");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == kcct_pkg::STATUS_NOT_FOUND ||
                      rsp_status == kcct_pkg::STATUS_FULL))
      |-> (rsp_entry_payload == 32'd0 && rsp_entry_time == 32'd0))
      else $error("miss or full result carries data");

   a_take_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && cmd_ff.do_take && match_found_ff)
      |=> !valid_ff[$past(match_idx_ff)])
      else $error("taken slot still valid");

   a_insert_sets: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("written slot not marked valid");

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the keyed cookie cache table.
`timescale 1ns / 1ps

module testbench;

   localparam logic [1:0] OP_RESERVED   = 2'd3;
   localparam int         RANDOM_ITEMS  = 1100;
   localparam int         POOL_KEYS     = 24;
   localparam int         STALL_LIMIT   = 1000;
   localparam int         SETTLE_CYCLES = 40;

   typedef struct {
      logic [1:0]  op;
      logic [63:0] cookie;
      logic [15:0] ctype;
      logic [31:0] payload;
      logic [31:0] now_time;
      int          gap;
      bit          drain;
   } cookie_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] payload;
      logic [31:0] stamp;
   } cookie_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = kcct_pkg::OP_INSERT;
   logic [63:0] req_cookie_value = '0;
   logic [15:0] req_cookie_type = '0;
   logic [31:0] req_payload = '0;
   logic [31:0] req_now_time = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_entry_payload;
   logic [31:0] rsp_entry_time;

   // Mirror of the slot table, updated in request order.
   logic        tbl_valid [kcct_pkg::TABLE_ENTRIES];
   logic [63:0] tbl_key [kcct_pkg::TABLE_ENTRIES];
   logic [15:0] tbl_type [kcct_pkg::TABLE_ENTRIES];
   logic [31:0] tbl_payload [kcct_pkg::TABLE_ENTRIES];
   logic [31:0] tbl_stamp [kcct_pkg::TABLE_ENTRIES];

   cookie_req_type pending_req[$];
   cookie_rsp_type expected_rsp[$];
   cookie_req_type cur_req;
   cookie_req_type shown_req;
   bit          have_req = 1'b0;
   int          gap_left = 0;
   int          accepted_cnt = 0;
   int          results_seen = 0;
   int          errors = 0;
   int          idle_cycles = 0;
   int          status_hits [5] = '{default: 0};

   logic [63:0] pool_cookie [POOL_KEYS];
   logic [15:0] pool_type [POOL_KEYS];

   keyed_cookie_cache_table u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_cookie_value  (req_cookie_value),
      .req_cookie_type   (req_cookie_type),
      .req_payload       (req_payload),
      .req_now_time      (req_now_time),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_entry_payload (rsp_entry_payload),
      .rsp_entry_time    (rsp_entry_time)
   );

   always #10 clock = ~clock;

   initial begin
      for (int i = 0; i < kcct_pkg::TABLE_ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Applies one request to the table mirror and returns the result it must give.
   function automatic cookie_rsp_type table_lookup_update(input cookie_req_type r);
      cookie_rsp_type res;
      int          hit;
      int          free_slot;
      int          s;
      res.status  = kcct_pkg::STATUS_NOT_FOUND;
      res.payload = '0;
      res.stamp   = '0;
      hit         = -1;
      free_slot   = -1;
      // Scanning downward leaves the lowest-numbered match and free slot.
      for (int i = kcct_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (tbl_valid[i] && tbl_type[i] == r.ctype &&
             ((tbl_key[i] ^ r.cookie) & kcct_pkg::KEY_MASK) == '0) hit = i;
         if (!tbl_valid[i]) free_slot = i;
      end
      case (r.op)
         kcct_pkg::OP_INSERT: begin
            s = (hit >= 0) ? hit : free_slot;
            if (s < 0) begin
               res.status = kcct_pkg::STATUS_FULL;
            end else begin
               res.status     = (hit >= 0) ? kcct_pkg::STATUS_REPLACED
                                           : kcct_pkg::STATUS_ADDED;
               tbl_valid[s]   = 1'b1;
               tbl_key[s]     = r.cookie;
               tbl_type[s]    = r.ctype;
               tbl_payload[s] = r.payload;
               tbl_stamp[s]   = r.now_time;
               res.payload    = r.payload;
               res.stamp      = r.now_time;
            end
         end
         kcct_pkg::OP_TAKE, kcct_pkg::OP_CHECK: begin
            if (hit >= 0) begin
               res.status  = kcct_pkg::STATUS_FOUND;
               res.payload = tbl_payload[hit];
               res.stamp   = tbl_stamp[hit];
               if (r.op == kcct_pkg::OP_TAKE) tbl_valid[hit] = 1'b0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic int pick_gap(input bit burst);
      int roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic queue_request(input logic [1:0] op, input int key_idx,
                                input logic [31:0] payload, input logic [31:0] now_time,
                                input int gap, input bit drain);
      cookie_req_type r;
      r.op       = op;
      r.cookie   = pool_cookie[key_idx];
      r.ctype    = pool_type[key_idx];
      r.payload  = payload;
      r.now_time = now_time;
      r.gap      = gap;
      r.drain    = drain;
      pending_req.push_back(r);
   endtask

   // Driver: presents queued requests, honoring per-request gaps and drain pauses.
   always @(posedge clock) begin : driver
      bit fire;
      bit next_start;
      int acc;
      if (reset) begin
         start        <= 1'b0;
         accepted_cnt <= 0;
      end else begin
         fire = start && !busy;
         acc  = accepted_cnt;
         if (fire) begin
            expected_rsp.push_back(table_lookup_update(shown_req));
            acc = acc + 1;
         end
         accepted_cnt <= acc;
         next_start = start && !fire;
         if (!next_start) begin
            if (!have_req && pending_req.size() > 0) begin
               cur_req  = pending_req.pop_front();
               have_req = 1'b1;
               gap_left = cur_req.gap;
            end
            if (have_req) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else if (!(cur_req.drain && acc != results_seen)) begin
                  next_start       = 1'b1;
                  shown_req        = cur_req;
                  have_req         = 1'b0;
                  req_operation    <= cur_req.op;
                  req_cookie_value <= cur_req.cookie;
                  req_cookie_type  <= cur_req.ctype;
                  req_payload      <= cur_req.payload;
                  req_now_time     <= cur_req.now_time;
               end
            end
         end
         start <= next_start;
      end
   end

   // Monitor: every strobed result is checked against the oldest expectation.
   always @(posedge clock) begin : monitor
      cookie_rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (results_seen >= accepted_cnt) begin
            errors++;
            $display("%0t: result with none expected: status %0d payload %0h time %0h",
                     $time, rsp_status, rsp_entry_payload, rsp_entry_time);
         end else begin
            want = expected_rsp.pop_front();
            status_hits[want.status]++;
            if (rsp_status !== want.status) begin
               errors++;
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_status);
            end
            if (rsp_entry_payload !== want.payload) begin
               errors++;
               $display("%0t: entry_payload mismatch: expected %08h, actual %08h",
                        $time, want.payload, rsp_entry_payload);
            end
            if (rsp_entry_time !== want.stamp) begin
               errors++;
               $display("%0t: entry_time mismatch: expected %08h, actual %08h",
                        $time, want.stamp, rsp_entry_time);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, accepted_cnt - results_seen);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int          total;
      int          phase_len;
      int          ins_pct;
      int          roll;
      int          key_idx;
      int          leftover;
      bit          burst;
      bit          drain;
      logic [1:0]  op;
      cookie_req_type r;

      // Key pool: extremes, near neighbors and same cookie under another type.
      pool_cookie[0] = '0;                      pool_type[0] = 16'h0000;
      pool_cookie[1] = '1;                      pool_type[1] = 16'hFFFF;
      pool_cookie[2] = '0;                      pool_type[2] = 16'h0001;
      pool_cookie[3] = 64'h0000_0000_0000_0001; pool_type[3] = 16'h0000;
      pool_cookie[4] = 64'h8000_0000_0000_0000; pool_type[4] = 16'h0000;
      for (int i = 5; i < POOL_KEYS; i++) begin
         case (i % 3)
            0: begin
               pool_cookie[i] = pool_cookie[i - 1] ^ (64'd1 << $urandom_range(0, 63));
               pool_type[i]   = pool_type[i - 1];
            end
            1: begin
               pool_cookie[i] = pool_cookie[i - 1];
               pool_type[i]   = pool_type[i - 1] ^ (16'd1 << $urandom_range(0, 15));
            end
            default: begin
               pool_cookie[i] = {$urandom, $urandom};
               pool_type[i]   = 16'($urandom);
            end
         endcase
      end

      queue_request(kcct_pkg::OP_INSERT, 0, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
      queue_request(kcct_pkg::OP_INSERT, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
      queue_request(kcct_pkg::OP_INSERT, 2, 32'h1111_2222, 32'h0000_0010, 0, 1'b0);
      queue_request(kcct_pkg::OP_INSERT, 3, 32'h3333_4444, 32'h0000_0011, 1, 1'b0);
      queue_request(kcct_pkg::OP_CHECK,  0, 32'hDEAD_BEEF, 32'h0000_0012, 0, 1'b0);
      queue_request(kcct_pkg::OP_CHECK,  2, 32'h0000_0000, 32'h0000_0013, 0, 1'b0);
      queue_request(kcct_pkg::OP_INSERT, 0, 32'hA5A5_A5A5, 32'h1234_5678, 0, 1'b0);
      queue_request(kcct_pkg::OP_CHECK,  0, 32'h0000_0000, 32'h0000_0014, 2, 1'b0);
      queue_request(kcct_pkg::OP_TAKE,   1, 32'h0000_0000, 32'h0000_0015, 0, 1'b0);
      queue_request(kcct_pkg::OP_TAKE,   1, 32'h0000_0000, 32'h0000_0016, 0, 1'b0);
      queue_request(kcct_pkg::OP_CHECK,  1, 32'h0000_0000, 32'h0000_0017, 0, 1'b0);
      queue_request(OP_RESERVED,         0, 32'h5A5A_5A5A, 32'h0000_0018, 0, 1'b0);
      queue_request(kcct_pkg::OP_CHECK,  0, 32'h0000_0000, 32'h0000_0019, 0, 1'b0);
      queue_request(kcct_pkg::OP_TAKE,   3, 32'h0000_0000, 32'h0000_001A, 0, 1'b0);
      queue_request(kcct_pkg::OP_INSERT, 4, 32'h8000_0001, 32'h7FFF_FFFF, 0, 1'b0);
      queue_request(kcct_pkg::OP_TAKE,   0, 32'h0000_0000, 32'h0000_001B, 0, 1'b0);
      queue_request(kcct_pkg::OP_TAKE,   2, 32'h0000_0000, 32'h0000_001C, 0, 1'b0);
      queue_request(kcct_pkg::OP_TAKE,   4, 32'h0000_0000, 32'h0000_001D, 0, 1'b0);
      total = pending_req.size();

      // Random phases pick a low, middle or high insert share to drain or fill the table.
      while (total < RANDOM_ITEMS + 18) begin
         phase_len = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0:       ins_pct = 25;
            1:       ins_pct = 55;
            default: ins_pct = 85;
         endcase
         burst = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < phase_len; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) op = OP_RESERVED;
            else if (roll < 3 + ins_pct) op = kcct_pkg::OP_INSERT;
            else if ($urandom_range(0, 1) == 1) op = kcct_pkg::OP_TAKE;
            else op = kcct_pkg::OP_CHECK;
            drain   = (n == 0 && $urandom_range(0, 2) == 0) || (total % 150 == 18);
            key_idx = $urandom_range(0, POOL_KEYS - 1);
            queue_request(op, key_idx, $urandom, $urandom, pick_gap(burst), drain);
            // About one request in ten uses a fresh random key that almost never matches a stored one.
            if ($urandom_range(0, 9) == 0) begin
               r        = pending_req.pop_back();
               r.cookie = {$urandom, $urandom};
               r.ctype  = 16'($urandom);
               pending_req.push_back(r);
            end
            total++;
         end
      end

      do @(negedge clock);
      while (!(!reset && pending_req.size() == 0 && !have_req && !start &&
               accepted_cnt == results_seen));
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      leftover = accepted_cnt - results_seen;
      if (leftover != 0) begin
         $display("%0t: %0d expected results never arrived", $time, leftover);
      end
      $display("Ran %0d requests with random gaps and drain pauses; %0d mismatches.",
               accepted_cnt, errors);
      $display("Results seen: added %0d, replaced %0d, found %0d, not found %0d, full %0d.",
               status_hits[kcct_pkg::STATUS_ADDED], status_hits[kcct_pkg::STATUS_REPLACED],
               status_hits[kcct_pkg::STATUS_FOUND], status_hits[kcct_pkg::STATUS_NOT_FOUND],
               status_hits[kcct_pkg::STATUS_FULL]);
      if (errors == 0 && leftover == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/kcct_pkg.sv
rtl/kcct_front.sv
rtl/kcct_queue.sv
rtl/kcct_back.sv
rtl/keyed_cookie_cache_table.sv
bench/testbench.sv
